// File: src/deq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and ring index helper for the double-ended queue
// no dependencies; imported by deq_ctrl and double_ended_queue
package deq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 64;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  // operation codes; the two spare codes behave as peek
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_PEEK       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } fsm_t;

  // memory requests from the controller
  typedef struct packed {
    logic wr_en;
    ptr_t wr_addr;
    logic rd_en;
    ptr_t rd_lo;
    ptr_t rd_hi;
  } mem_req_t;

  // result side status from the controller
  typedef struct packed {
    logic    done;
    logic    busy;
    status_t status;
    cnt_t    count;
    logic    rev;
  } ctrl_stat_t;

  // ring slot at base + off, modulo DEPTH (off can exceed DEPTH: rd_hi passes count - 1, which wraps when empty)
  function automatic ptr_t slot_add(ptr_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: src/double_ended_queue.sv
`timescale 1ns / 1ps
// double-ended queue top level: ring memory, controller and result outputs
// depends on deq_pkg and deq_ctrl
// sequencing: an accepted start moves to the read state, then to the result state where done rises
// a new start may be taken in the result state but not in the read state, where busy is high;
// the limit is the registered read of both ends of the ring memory
// reset: synchronous rst empties the queue and restores normal orientation
// the receiver cannot stall: each result shows for exactly one cycle
module double_ended_queue
  import deq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [63:0] entry_value,
  output logic        done,
  output logic [1:0]  status,
  output logic [6:0]  entry_count,
  output logic        is_empty,
  output logic [63:0] front_value,
  output logic [63:0] back_value
);

  mem_req_t   mem_req;
  ctrl_stat_t stat;
  word_t      mem [DEPTH];
  word_t      rd_lo_data;
  word_t      rd_hi_data;
  word_t      front_word;
  word_t      back_word;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .mem_req   (mem_req),
    .stat      (stat)
  );

  // ring memory write port
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= entry_value[DATA_WIDTH-1:0];
    end
  end

  // ring memory read ports for the low and high ends
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_lo_data <= mem[mem_req.rd_lo];
      rd_hi_data <= mem[mem_req.rd_hi];
    end
  end

  // orientation picks which end is the front; empty reads as zero
  always_comb begin
    if (stat.count == '0) begin
      front_word = '0;
      back_word  = '0;
    end else if (stat.rev) begin
      front_word = rd_hi_data;
      back_word  = rd_lo_data;
    end else begin
      front_word = rd_lo_data;
      back_word  = rd_hi_data;
    end
  end

  assign busy        = stat.busy;
  assign done        = stat.done;
  assign status      = 2'(stat.status);
  assign entry_count = 7'(stat.count);
  assign is_empty    = (stat.count == '0);
  assign front_value = 64'(front_word);
  assign back_value  = 64'(back_word);

endmodule

// File: src/deq_ctrl.sv
`timescale 1ns / 1ps
// deque controller: head pointer, count, orientation and transaction sequencing
// depends on deq_pkg; drives the ring memory held in double_ended_queue
module deq_ctrl
  import deq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] operation,
  output mem_req_t   mem_req,
  output ctrl_stat_t stat
);

  fsm_t    state, state_next;
  ptr_t    head, head_next;
  cnt_t    count, count_next;
  logic    rev, rev_next;
  status_t status, status_next;
  logic    accept;
  logic    full, empty;
  logic    wr_en;
  ptr_t    wr_addr;

  assign accept = start && (state != S_READ);
  assign full   = (count == cnt_t'(DEPTH));
  assign empty  = (count == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = S_SHOW;
      S_SHOW: begin
        if (accept) state_next = S_READ;
        else        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pointer, count and orientation update for an accepted transaction
  always_comb begin
    head_next   = head;
    count_next  = count;
    rev_next    = rev;
    status_next = status;
    wr_en       = 1'b0;
    wr_addr     = slot_add(head, count);
    if (accept) begin
      status_next = STAT_OK;
      unique case (operation) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            status_next = STAT_FULL;
          end else if ((operation == OP_PUSH_FRONT) != rev) begin
            head_next  = (head == '0) ? ptr_t'(DEPTH - 1) : head - 1'b1;
            wr_addr    = head_next;
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            status_next = STAT_EMPTY;
          end else if ((operation == OP_POP_FRONT) != rev) begin
            head_next  = slot_add(head, cnt_t'(1));
            count_next = count - 1'b1;
          end else begin
            count_next = count - 1'b1;
          end
        end
        OP_REVERSE: begin
          if (empty) status_next = STAT_EMPTY;
          else       rev_next    = !rev;
        end
        default: ;
      endcase
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      rev    <= 1'b0;
      status <= STAT_OK;
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      rev    <= rev_next;
      status <= status_next;
    end
  end

  // outputs: writes land at accept, reads of both ends follow in the read state
  always_comb begin
    mem_req.wr_en   = wr_en;
    mem_req.wr_addr = wr_addr;
    mem_req.rd_en   = (state == S_READ);
    mem_req.rd_lo   = head;
    mem_req.rd_hi   = slot_add(head, count - 1'b1);
    stat.done       = (state == S_SHOW);
    stat.busy       = (state == S_READ);
    stat.status     = status;
    stat.count      = count;
    stat.rev        = rev;
  end

  // count stays within the ring
  assert property (@(posedge clk) disable iff (rst) count <= cnt_t'(DEPTH))
    else $error("deque count exceeds depth");

  // every accepted transaction is followed by a read cycle, then a result
  assert property (@(posedge clk) disable iff (rst) accept |=> (state == S_READ))
    else $error("accepted transaction not followed by read");

  assert property (@(posedge clk) disable iff (rst) (state == S_READ) |=> (state == S_SHOW))
    else $error("read cycle not followed by result");

  // no memory write while the read of both ends is in flight
  assert property (@(posedge clk) disable iff (rst) (state == S_READ) |-> !wr_en)
    else $error("write overlaps read cycle");

  // a refused push leaves the count unchanged
  assert property (@(posedge clk) disable iff (rst)
                   (accept && full && (operation == OP_PUSH_FRONT ||
                    operation == OP_PUSH_BACK)) |=> (count == $past(count)))
    else $error("refused push changed the count");

endmodule
